// ===== rtl/hsc_pkg.sv =====
package hsc_pkg;

   localparam int CNT_W      = 16;
   localparam int MS_W       = 16;
   localparam int PP_W       = 7;
   localparam int DUTY_W     = 7;
   localparam int TABLE_W    = 32;
   localparam int SPEED_W    = 24;
   localparam int HALL_W     = 3;
   localparam int ENTRY_W    = 4;
   localparam int CAUSE_W    = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // rpm = count * 60000 / (6 * ms) / poles = count * 10000 / (ms * poles)
   localparam int SCALE_W = 14;
   localparam logic [SCALE_W-1:0] SPEED_SCALE = 14'd10000;

   localparam int NUM_W  = CNT_W + SCALE_W;
   localparam int DEN_W  = MS_W + PP_W;
   localparam int STEP_W = $clog2(NUM_W);

   localparam logic [ENTRY_W-1:0] NO_DRIVE  = 4'hF;
   localparam logic [1:0]         PHASE_OFF = 2'd3;

   localparam logic [CAUSE_W-1:0] STOP_NONE = 2'd0;
   localparam logic [CAUSE_W-1:0] STOP_KILL = 2'd1;
   localparam logic [CAUSE_W-1:0] STOP_HALL = 2'd2;

   localparam logic [TABLE_W-1:0] TABLE_RST  = 32'hF246918F;
   localparam logic [DUTY_W-1:0]  DUTY_RST   = 7'd50;
   localparam logic [DUTY_W-1:0]  DUTY_MAX   = 7'd100;
   localparam logic [MS_W-1:0]    WINDOW_RST = 16'd2000;
   localparam logic [PP_W-1:0]    POLES_RST  = 7'd4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TABLE  = 2'd0,
      CSR_DUTY   = 2'd1,
      CSR_WINDOW = 2'd2,
      CSR_POLES  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_CALC,
      CTL_PUSH
   } ctl_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_DIV
   } div_state_type;

   typedef struct packed {
      logic [HALL_W-1:0] hall_code;
      logic              kill;
      logic              ms_tick;
   } req_type;

   typedef struct packed {
      logic [2:0]         phase_enable;
      logic [2:0]         pwm_phases;
      logic [DUTY_W-1:0]  drive_duty;
      logic               halted;
      logic [CAUSE_W-1:0] stop_cause;
      logic [HALL_W-1:0]  hall_state;
      logic [SPEED_W-1:0] speed_rpm;
      logic               speed_valid;
   } rsp_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } div_sts_type;

endpackage

// ===== rtl/hsc_speed_div.sv =====
module hsc_speed_div
   import hsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic [CNT_W-1:0]   count,
   input  logic [MS_W-1:0]    elapsed,
   input  logic [PP_W-1:0]    poles,
   output div_sts_type        sts,
   output logic [SPEED_W-1:0] rpm
);

   div_state_type state_ff, state_in;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  csh_ff, csh_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  esh_ff, esh_in;
   logic [PP_W-1:0]   ppsh_ff, ppsh_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] trial;
   logic           fits;
   logic           mul_last;
   logic           div_last;

   assign mul_last = (step_ff == STEP_W'(SCALE_W - 1));
   assign div_last = (step_ff == STEP_W'(NUM_W - 1));
   assign trial    = {rem_ff, num_ff[NUM_W-1]};
   assign fits     = (trial >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (ctl.start) state_in = DIV_MUL;
         DIV_MUL:  if (mul_last) state_in = DIV_DIV;
         DIV_DIV:  if (div_last) state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      num_in  = num_ff;
      csh_in  = csh_ff;
      den_in  = den_ff;
      esh_in  = esh_ff;
      ppsh_in = ppsh_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (ctl.start) begin
               step_in = '0;
               num_in  = '0;
               csh_in  = NUM_W'(count);
               den_in  = '0;
               esh_in  = DEN_W'(elapsed);
               ppsh_in = poles;
               rem_in  = '0;
            end
         end
         DIV_MUL: begin
            // shift-add: one bit of the scale constant and of the pole count a cycle
            if (SPEED_SCALE[step_ff[$clog2(SCALE_W)-1:0]]) num_in = num_ff + csh_ff;
            if (ppsh_ff[0]) den_in = den_ff + esh_ff;
            csh_in  = {csh_ff[NUM_W-2:0], 1'b0};
            esh_in  = {esh_ff[DEN_W-2:0], 1'b0};
            ppsh_in = {1'b0, ppsh_ff[PP_W-1:1]};
            step_in = mul_last ? '0 : step_ff + 1'b1;
         end
         DIV_DIV: begin
            // restoring division, quotient bits shift in behind the dividend
            rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            num_in  = {num_ff[NUM_W-2:0], fits};
            step_in = step_ff + 1'b1;
            done_in = div_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      csh_ff  <= csh_in;
      den_ff  <= den_in;
      esh_ff  <= esh_in;
      ppsh_ff <= ppsh_in;
      rem_ff  <= rem_in;
   end

   assign sts.done = done_ff;
   assign sts.busy = (state_ff != DIV_IDLE);
   assign rpm = (num_ff[NUM_W-1:SPEED_W] != '0) ? {SPEED_W{1'b1}} : num_ff[SPEED_W-1:0];

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == DIV_IDLE)
      else $error("speed divider started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("speed divider done held more than one cycle");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_DIV |-> den_ff != '0)
      else $error("speed divider dividing by zero");
`endif

endmodule

// ===== rtl/hall_six_step_commutator.sv =====
// one result beat per sample beat
// a sample is registered on accept and its beat is loaded in CTL_PUSH; when
//   it closes a speed window, CTL_CALC first runs the bit-serial multiply then divide
// a new sample is taken only in CTL_IDLE, after the last result is loaded;
//   the next sample is taken while a result still waits on rsp_ready
// reset: synchronous, active high; registers to defaults, drive off, not halted
module hall_six_step_commutator
   import hsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TABLE_W-1:0] table_ff;
   logic [DUTY_W-1:0]  duty_ff;
   logic [MS_W-1:0]    window_ff;
   logic [PP_W-1:0]    poles_ff;

   ctl_state_type state_ff, state_in;

   logic               started_ff, started_in;
   logic               halted_ff, halted_in;
   logic [CAUSE_W-1:0] cause_ff, cause_in;
   logic [HALL_W-1:0]  prev_ff, prev_in;
   logic [ENTRY_W-1:0] drive_ff, drive_in;
   logic [CNT_W-1:0]   trans_ff, trans_in;
   logic [MS_W-1:0]    elapsed_ff, elapsed_in;
   logic [SPEED_W-1:0] speed_ff;
   logic               close_ff, close_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               accept;
   logic               load_rsp;
   logic [ENTRY_W-1:0] nib;
   logic [MS_W-1:0]    elapsed_tick;
   logic [MS_W-1:0]    window_eff;
   logic [CNT_W-1:0]   div_count;
   logic [MS_W-1:0]    div_elapsed;
   logic [PP_W-1:0]    poles_eff;
   div_ctl_type        div_ctl;
   div_sts_type        div_sts;
   logic [SPEED_W-1:0] div_rpm;
   rsp_type            rsp_next;
   logic [1:0]         hi, lo;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff  <= TABLE_RST;
         duty_ff   <= DUTY_RST;
         window_ff <= WINDOW_RST;
         poles_ff  <= POLES_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_TABLE:  table_ff  <= csr_wdata[TABLE_W-1:0];
            CSR_DUTY:   duty_ff   <= csr_wdata[DUTY_W-1:0];
            CSR_WINDOW: window_ff <= csr_wdata[MS_W-1:0];
            CSR_POLES:  poles_ff  <= csr_wdata[PP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign nib          = table_ff[{req_data.hall_code, 2'b00} +: ENTRY_W];
   assign window_eff   = (window_ff == '0) ? MS_W'(1) : window_ff;
   assign poles_eff    = (poles_ff == '0) ? PP_W'(1) : poles_ff;
   assign elapsed_tick = (req_data.ms_tick && elapsed_ff != {MS_W{1'b1}}) ?
                         elapsed_ff + 1'b1 : elapsed_ff;

   // per-sample drive and counter update
   always_comb begin
      started_in  = started_ff;
      halted_in   = halted_ff;
      cause_in    = cause_ff;
      prev_in     = prev_ff;
      drive_in    = drive_ff;
      trans_in    = trans_ff;
      elapsed_in  = elapsed_ff;
      close_in    = 1'b0;
      div_count   = trans_ff;
      div_elapsed = elapsed_tick;
      if (!halted_ff) begin
         if (!started_ff) begin
            started_in = 1'b1;
            if (req_data.kill) begin
               halted_in = 1'b1;
               cause_in  = STOP_KILL;
               drive_in  = NO_DRIVE;
            end else if (nib[1:0] == PHASE_OFF) begin
               halted_in = 1'b1;
               cause_in  = STOP_HALL;
               drive_in  = NO_DRIVE;
            end else begin
               drive_in = nib;
               prev_in  = req_data.hall_code;
            end
         end else if (req_data.kill) begin
            halted_in = 1'b1;
            cause_in  = STOP_KILL;
            drive_in  = NO_DRIVE;
         end else if (req_data.hall_code != prev_ff && nib[1:0] == PHASE_OFF) begin
            halted_in = 1'b1;
            cause_in  = STOP_HALL;
            drive_in  = NO_DRIVE;
         end else begin
            if (req_data.hall_code != prev_ff) begin
               drive_in = nib;
               prev_in  = req_data.hall_code;
               if (trans_ff != {CNT_W{1'b1}}) trans_in = trans_ff + 1'b1;
            end
            div_count  = trans_in;
            elapsed_in = elapsed_tick;
            if (elapsed_tick >= window_eff) begin
               close_in   = 1'b1;
               trans_in   = '0;
               elapsed_in = '0;
            end
         end
      end
   end

   // control sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: if (accept) state_in = close_in ? CTL_CALC : CTL_PUSH;
         CTL_CALC: if (div_sts.done) state_in = CTL_PUSH;
         CTL_PUSH: if (load_rsp) state_in = CTL_IDLE;
         default:  state_in = CTL_IDLE;
      endcase
   end

   // control sequencer: outputs
   always_comb begin
      req_ready     = 1'b0;
      div_ctl.start = 1'b0;
      load_rsp      = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_ready     = 1'b1;
            div_ctl.start = req_valid && close_in;
         end
         CTL_CALC: begin
         end
         CTL_PUSH: load_rsp = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   hsc_speed_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .count   (div_count),
      .elapsed (div_elapsed),
      .poles   (poles_eff),
      .sts     (div_sts),
      .rpm     (div_rpm)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CTL_IDLE;
         started_ff <= 1'b0;
         halted_ff  <= 1'b0;
         cause_ff   <= STOP_NONE;
         prev_ff    <= '0;
         drive_ff   <= NO_DRIVE;
         trans_ff   <= '0;
         elapsed_ff <= '0;
         speed_ff   <= '0;
         close_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            started_ff <= started_in;
            halted_ff  <= halted_in;
            cause_ff   <= cause_in;
            prev_ff    <= prev_in;
            drive_ff   <= drive_in;
            trans_ff   <= trans_in;
            elapsed_ff <= elapsed_in;
            close_ff   <= close_in;
         end
         if (div_sts.done) speed_ff <= div_rpm;
      end
   end

   // result beat built from the updated state
   assign hi = drive_ff[1:0];
   assign lo = drive_ff[3:2];

   always_comb begin
      rsp_next              = '0;
      rsp_next.halted       = halted_ff;
      rsp_next.stop_cause   = cause_ff;
      rsp_next.hall_state   = prev_ff;
      rsp_next.speed_rpm    = speed_ff;
      rsp_next.speed_valid  = close_ff;
      if (!halted_ff && hi != PHASE_OFF) begin
         rsp_next.pwm_phases   = 3'b001 << hi;
         rsp_next.phase_enable = 3'b001 << hi;
         if (lo != PHASE_OFF && lo != hi) begin
            rsp_next.phase_enable = rsp_next.phase_enable | (3'b001 << lo);
         end
         rsp_next.drive_duty = (duty_ff > DUTY_MAX) ? DUTY_MAX : duty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) rsp_data_ff <= rsp_next;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_halt_latched: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted state released without reset");
   a_halt_drive_off: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> drive_ff == NO_DRIVE && cause_ff != STOP_NONE)
      else $error("drive entry live while halted");
   a_halt_beat_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.halted |->
         rsp_data_ff.phase_enable == '0 && rsp_data_ff.drive_duty == '0)
      else $error("halted beat still drives a phase");
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == CTL_CALC)
      else $error("speed result arrived outside calc");
   a_calc_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTL_CALC && !div_sts.done |-> div_sts.busy)
      else $error("calc waiting on idle divider");
`endif

endmodule
